// ===== rtl/core/rsm_pkg.sv =====
`default_nettype none

package rsm_pkg;

    // table sizing
    localparam int MAX_SLOTS   = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int REF_WIDTH   = 16;
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int COUNT_W     = $clog2(MAX_SLOTS + 1);

    localparam logic [COUNT_W-1:0]   SLOTS_FULL = COUNT_W'(MAX_SLOTS);
    localparam logic [REF_WIDTH-1:0] REF_MAX    = '1;

    // operation codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_INCR   = 3'd2;
    localparam logic [2:0] OP_DECR   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BAD      = 3'd2;
    localparam logic [2:0] ST_NONZERO  = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    typedef struct packed {
        logic [2:0]             operation;
        logic [SLOT_W-1:0]      handle;
        logic [VALUE_WIDTH-1:0] element_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [SLOT_W-1:0]      handle_out;
        logic [VALUE_WIDTH-1:0] value_out;
        logic [REF_WIDTH-1:0]   refcount_out;
        logic                   freed;
        logic [COUNT_W-1:0]     live_elements;
    } out_word_t;

    // one entry of the dense store
    typedef struct packed {
        logic [SLOT_W-1:0]      owner;
        logic [VALUE_WIDTH-1:0] value;
    } dense_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_WRITE,
        S_SLOT,
        S_MOVE,
        S_READ,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsm_ram.sv =====
`default_nettype none

module rsm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when idle
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/refcounted_slot_map.sv =====
// Sequence: an accepted word goes through S_INS_WRITE (insert) or S_SLOT, then S_READ
//   (read) or S_MOVE (delete with relocation) where needed, then S_DONE, before its result
//   word appears on m_*. One word at a time: s_ready is high only in S_IDLE. The slot read,
//   dense read and dense/slot write-back use memories with one write and one read port each.
// Reset: aresetn synchronous, active low; clears counters, live bits and the
//   result valid flag. Memory contents are left as they are, no clearing pass.
`default_nettype none

module refcounted_slot_map (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rsm_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rsm_pkg::out_word_t      m_data
);

    import rsm_pkg::*;

    state_t state_reg, state_next;

    // control registers
    logic [COUNT_W-1:0]   issued_reg;
    logic [COUNT_W-1:0]   fdepth_reg;
    logic [COUNT_W-1:0]   dcount_reg;
    logic [MAX_SLOTS-1:0] live_reg;
    logic                 m_valid_reg;

    // payload registers
    logic [2:0]             op_reg;
    logic [SLOT_W-1:0]      handle_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   pop_reg;
    logic [SLOT_W-1:0]      nh_reg;
    logic [SLOT_W-1:0]      pos_reg;
    out_word_t              res_reg;
    out_word_t              m_data_reg;

    // memory ports
    logic                 pos_we, pos_re;
    logic [SLOT_W-1:0]    pos_waddr, pos_raddr, pos_wdata, pos_rdata;
    logic                 refs_we, refs_re;
    logic [SLOT_W-1:0]    refs_waddr, refs_raddr;
    logic [REF_WIDTH-1:0] refs_wdata, refs_rdata;
    logic                 dense_we, dense_re;
    logic [SLOT_W-1:0]    dense_waddr, dense_raddr;
    dense_word_t          dense_wdata, dense_rdata;
    logic                 free_we, free_re;
    logic [SLOT_W-1:0]    free_waddr, free_raddr, free_wdata, free_rdata;

    // decode of the incoming word
    logic accept, in_handle_ok, in_is_ref_op, in_has_free, in_has_fresh;
    logic out_free;

    assign accept       = s_valid && s_ready;
    assign in_is_ref_op = (s_data.operation == OP_DELETE) || (s_data.operation == OP_INCR) ||
                          (s_data.operation == OP_DECR) || (s_data.operation == OP_READ);
    assign in_handle_ok = (COUNT_W'(s_data.handle) < issued_reg) && live_reg[s_data.handle];
    assign in_has_free  = (fdepth_reg != '0);
    assign in_has_fresh = (issued_reg != SLOTS_FULL);
    assign out_free     = !m_valid_reg || m_ready;

    // decisions on the fetched slot entry
    logic                 ref_zero, ref_sat, do_remove, need_move;
    logic [REF_WIDTH-1:0] refs_inc, refs_dec;
    logic [COUNT_W-1:0]   dense_last;
    logic [SLOT_W-1:0]    ins_handle;

    assign ref_zero   = (refs_rdata == '0);
    assign ref_sat    = (refs_rdata == REF_MAX);
    assign refs_inc   = refs_rdata + REF_WIDTH'(1);
    assign refs_dec   = refs_rdata - REF_WIDTH'(1);
    assign do_remove  = ((op_reg == OP_DELETE) && ref_zero) ||
                        ((op_reg == OP_DECR) && !ref_zero && (refs_dec == '0));
    assign dense_last = dcount_reg - COUNT_W'(1);
    assign need_move  = do_remove && (dcount_reg != '0) &&
                        (dense_last[SLOT_W-1:0] != pos_rdata);
    assign ins_handle = pop_reg ? free_rdata : nh_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.operation == OP_INSERT) begin
                        state_next = (in_has_free || in_has_fresh) ? S_INS_WRITE : S_DONE;
                    end else if (in_is_ref_op && in_handle_ok) begin
                        state_next = S_SLOT;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_INS_WRITE: state_next = S_DONE;
            S_SLOT: begin
                if (op_reg == OP_READ) begin
                    state_next = S_READ;
                end else if (need_move) begin
                    state_next = S_MOVE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MOVE:  state_next = S_DONE;
            S_READ:  state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory requests and handshake outputs
    always_comb begin
        s_ready     = 1'b0;
        pos_we      = 1'b0;
        pos_waddr   = '0;
        pos_wdata   = '0;
        pos_re      = 1'b0;
        pos_raddr   = s_data.handle;
        refs_we     = 1'b0;
        refs_waddr  = handle_reg;
        refs_wdata  = '0;
        refs_re     = 1'b0;
        refs_raddr  = s_data.handle;
        dense_we    = 1'b0;
        dense_waddr = '0;
        dense_wdata = '0;
        dense_re    = 1'b0;
        dense_raddr = pos_rdata;
        free_we     = 1'b0;
        free_waddr  = fdepth_reg[SLOT_W-1:0];
        free_wdata  = handle_reg;
        free_re     = 1'b0;
        free_raddr  = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.operation == OP_INSERT) begin
                        free_re    = in_has_free;
                        free_raddr = SLOT_W'(fdepth_reg - COUNT_W'(1));
                    end else if (in_is_ref_op && in_handle_ok) begin
                        pos_re  = 1'b1;
                        refs_re = 1'b1;
                    end
                end
            end
            S_INS_WRITE: begin
                if (dcount_reg != SLOTS_FULL) begin
                    pos_we            = 1'b1;
                    pos_waddr         = ins_handle;
                    pos_wdata         = dcount_reg[SLOT_W-1:0];
                    refs_we           = 1'b1;
                    refs_waddr        = ins_handle;
                    dense_we          = 1'b1;
                    dense_waddr       = dcount_reg[SLOT_W-1:0];
                    dense_wdata.owner = ins_handle;
                    dense_wdata.value = value_reg;
                end
            end
            S_SLOT: begin
                unique case (op_reg)
                    OP_READ: dense_re = 1'b1;
                    OP_INCR: begin
                        refs_we    = !ref_sat;
                        refs_wdata = refs_inc;
                    end
                    OP_DECR: begin
                        refs_we    = !ref_zero;
                        refs_wdata = refs_dec;
                    end
                    OP_DELETE: begin
                        refs_we = ref_zero;
                    end
                    default: ;
                endcase
                if (do_remove) begin
                    free_we     = (fdepth_reg != SLOTS_FULL);
                    dense_re    = need_move;
                    dense_raddr = dense_last[SLOT_W-1:0];
                end
            end
            S_MOVE: begin
                // last dense entry fills the hole, its handle repointed
                dense_we    = 1'b1;
                dense_waddr = pos_reg;
                dense_wdata = dense_rdata;
                pos_we      = 1'b1;
                pos_waddr   = dense_rdata.owner;
                pos_wdata   = pos_reg;
            end
            S_READ: ;
            S_DONE: ;
            default: ;
        endcase
    end

    // state, counters and live bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            issued_reg  <= '0;
            fdepth_reg  <= '0;
            dcount_reg  <= '0;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // result valid: loaded on leaving S_DONE, dropped once taken
            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept && (s_data.operation == OP_INSERT)) begin
                        if (in_has_free) begin
                            fdepth_reg <= fdepth_reg - COUNT_W'(1);
                        end else if (in_has_fresh) begin
                            issued_reg <= issued_reg + COUNT_W'(1);
                        end
                    end
                end
                S_INS_WRITE: begin
                    if (dcount_reg != SLOTS_FULL) begin
                        live_reg[ins_handle] <= 1'b1;
                        dcount_reg           <= dcount_reg + COUNT_W'(1);
                    end
                end
                S_SLOT: begin
                    if (do_remove) begin
                        live_reg[handle_reg] <= 1'b0;
                        if (fdepth_reg != SLOTS_FULL) begin
                            fdepth_reg <= fdepth_reg + COUNT_W'(1);
                        end
                        if (dcount_reg != '0) begin
                            dcount_reg <= dense_last;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // item payload and result assembly
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_reg               <= s_data.operation;
                    handle_reg           <= s_data.handle;
                    value_reg            <= s_data.element_value;
                    pop_reg              <= in_has_free;
                    nh_reg               <= issued_reg[SLOT_W-1:0];
                    res_reg.value_out    <= '0;
                    res_reg.refcount_out <= '0;
                    res_reg.freed        <= 1'b0;
                    res_reg.live_elements <= '0;
                    if ((s_data.operation == OP_INSERT) && !in_has_free && !in_has_fresh) begin
                        res_reg.status     <= ST_FULL;
                        res_reg.handle_out <= '0;
                    end else if (in_is_ref_op && !in_handle_ok) begin
                        res_reg.status     <= ST_BAD;
                        res_reg.handle_out <= s_data.handle;
                    end else begin
                        res_reg.status     <= ST_OK;
                        res_reg.handle_out <= s_data.handle;
                    end
                end
            end
            S_INS_WRITE: begin
                if (dcount_reg != SLOTS_FULL) begin
                    res_reg.handle_out <= ins_handle;
                end else begin
                    res_reg.status     <= ST_FULL;
                    res_reg.handle_out <= '0;
                end
            end
            S_SLOT: begin
                pos_reg <= pos_rdata;
                unique case (op_reg)
                    OP_READ: res_reg.refcount_out <= refs_rdata;
                    OP_INCR: begin
                        if (ref_sat) begin
                            res_reg.status       <= ST_OVERFLOW;
                            res_reg.refcount_out <= refs_rdata;
                        end else begin
                            res_reg.refcount_out <= refs_inc;
                        end
                    end
                    OP_DECR: begin
                        if (ref_zero) begin
                            res_reg.status <= ST_ZERO;
                        end else begin
                            res_reg.refcount_out <= refs_dec;
                        end
                    end
                    OP_DELETE: begin
                        if (!ref_zero) begin
                            res_reg.status       <= ST_NONZERO;
                            res_reg.refcount_out <= refs_rdata;
                        end
                    end
                    default: ;
                endcase
                if (do_remove) begin
                    res_reg.freed <= 1'b1;
                end
            end
            S_READ: res_reg.value_out <= dense_rdata.value;
            S_DONE: begin
                if (out_free) begin
                    m_data_reg <= out_word_t'({res_reg.status, res_reg.handle_out,
                                               res_reg.value_out, res_reg.refcount_out,
                                               res_reg.freed, dcount_reg});
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // handle -> dense position
    rsm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // handle -> reference count
    rsm_ram #(.WIDTH(REF_WIDTH), .DEPTH(MAX_SLOTS)) u_refs_ram (
        .aclk  (aclk),
        .we    (refs_we),
        .waddr (refs_waddr),
        .wdata (refs_wdata),
        .re    (refs_re),
        .raddr (refs_raddr),
        .rdata (refs_rdata)
    );

    // packed values with owning handle
    rsm_ram #(.WIDTH($bits(dense_word_t)), .DEPTH(MAX_SLOTS)) u_dense_ram (
        .aclk  (aclk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .re    (dense_re),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    // stack of freed handles
    rsm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .re    (free_re),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    // every issued handle is either live or on the free stack
    a_handle_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |->
            ((COUNT_W + 1)'(dcount_reg) + (COUNT_W + 1)'(fdepth_reg) ==
             (COUNT_W + 1)'(issued_reg)))
        else $error("issued handles do not balance live and free counts");

    // live bits agree with the dense fill
    a_live_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ($countones(live_reg) == int'(dcount_reg)))
        else $error("live bit count differs from dense count");

    // element and issue counters never exceed the table
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (dcount_reg <= SLOTS_FULL) && (issued_reg <= SLOTS_FULL))
        else $error("element or issue count beyond table size");

endmodule

`default_nettype wire

// ===== sim/slot_map_checker.sv =====
`default_nettype none

module slot_map_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire rsm_pkg::in_word_t  s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire rsm_pkg::out_word_t m_data,
    output int                      fail_count,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    // shadow copy of the handle table
    logic [SLOT_W-1:0]      handle_pos     [MAX_SLOTS];
    logic [REF_WIDTH-1:0]   handle_refs    [MAX_SLOTS];
    logic                   handle_live    [MAX_SLOTS];
    logic [COUNT_W-1:0]     handles_issued;
    logic [SLOT_W-1:0]      recycled       [MAX_SLOTS];
    logic [COUNT_W-1:0]     recycled_depth;
    logic [SLOT_W-1:0]      packed_owner   [MAX_SLOTS];
    logic [VALUE_WIDTH-1:0] packed_value   [MAX_SLOTS];
    logic [COUNT_W-1:0]     live_count;

    out_word_t expected_results[$];
    out_word_t want;
    int        errors = 0;

    // free a live handle, fill its hole with the last packed entry
    function automatic void release_handle(logic [SLOT_W-1:0] h);
        logic [SLOT_W-1:0] hole;
        logic [SLOT_W-1:0] tail;
        logic [SLOT_W-1:0] mover;
        hole = handle_pos[h];
        handle_live[h] = 1'b0;
        handle_refs[h] = '0;
        if (recycled_depth < SLOTS_FULL) begin
            recycled[recycled_depth[SLOT_W-1:0]] = h;
            recycled_depth++;
        end
        if (live_count == 0)
            return;
        tail = SLOT_W'(live_count - 1'b1);
        if (tail != hole) begin
            mover = packed_owner[tail];
            packed_value[hole] = packed_value[tail];
            packed_owner[hole] = mover;
            handle_pos[mover] = hole;
        end
        live_count--;
    endfunction

    // update the shadow table for one word and return the result it causes
    function automatic out_word_t apply_op(in_word_t w);
        out_word_t         r;
        logic [SLOT_W-1:0] h;
        logic [SLOT_W-1:0] nh;
        logic              got;
        h = w.handle;
        nh = '0;
        got = 1'b1;
        r = '0;
        r.status = ST_OK;
        r.handle_out = h;
        case (w.operation)
            OP_INSERT: begin
                // last freed handle first, then a fresh one
                if (recycled_depth != 0) begin
                    recycled_depth--;
                    nh = recycled[recycled_depth[SLOT_W-1:0]];
                end else if (handles_issued < SLOTS_FULL) begin
                    nh = handles_issued[SLOT_W-1:0];
                    handles_issued++;
                end else begin
                    got = 1'b0;
                end
                if (got && live_count < SLOTS_FULL) begin
                    handle_live[nh] = 1'b1;
                    handle_refs[nh] = '0;
                    handle_pos[nh] = live_count[SLOT_W-1:0];
                    packed_owner[live_count[SLOT_W-1:0]] = nh;
                    packed_value[live_count[SLOT_W-1:0]] = w.element_value;
                    live_count++;
                    r.handle_out = nh;
                end else begin
                    r.status = ST_FULL;
                    r.handle_out = '0;
                end
            end
            OP_DELETE, OP_INCR, OP_DECR, OP_READ: begin
                if (!(COUNT_W'(h) < handles_issued && handle_live[h])) begin
                    r.status = ST_BAD;
                end else begin
                    case (w.operation)
                        OP_DELETE: begin
                            if (handle_refs[h] != 0) begin
                                r.status = ST_NONZERO;
                                r.refcount_out = handle_refs[h];
                            end else begin
                                release_handle(h);
                                r.freed = 1'b1;
                            end
                        end
                        OP_INCR: begin
                            if (handle_refs[h] == REF_MAX)
                                r.status = ST_OVERFLOW;
                            else
                                handle_refs[h]++;
                            r.refcount_out = handle_refs[h];
                        end
                        OP_DECR: begin
                            if (handle_refs[h] == 0) begin
                                r.status = ST_ZERO;
                            end else begin
                                handle_refs[h]--;
                                r.refcount_out = handle_refs[h];
                                // last reference gone: element goes too
                                if (handle_refs[h] == 0) begin
                                    release_handle(h);
                                    r.freed = 1'b1;
                                end
                            end
                        end
                        default: begin
                            r.value_out = packed_value[handle_pos[h]];
                            r.refcount_out = handle_refs[h];
                        end
                    endcase
                end
            end
            default: ;
        endcase
        r.live_elements = live_count;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // watch both channels; results are checked before new words are predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_results.delete();
            foreach (handle_live[i])
                handle_live[i] = 1'b0;
            handles_issued = '0;
            recycled_depth = '0;
            live_count = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: %h", m_data);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_data.status);
                    check_field("handle_out", want.handle_out, m_data.handle_out);
                    check_field("value_out", want.value_out, m_data.value_out);
                    check_field("refcount_out", want.refcount_out, m_data.refcount_out);
                    check_field("freed", want.freed, m_data.freed);
                    check_field("live_elements", want.live_elements, m_data.live_elements);
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(apply_op(s_data));
        end
        fail_count <= errors;
        outstanding <= expected_results.size();
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    // operation codes the block does not define
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_word_t  s_data  = '0;
    logic      m_ready = 1'b0;
    wire logic s_ready;
    wire logic m_valid;
    out_word_t m_data;

    int fail_count;
    int outstanding;
    bit at_speed   = 1'b0;
    int calm_left  = 0;
    int ready_left = 0;

    always #10 aclk = ~aclk;

    refcounted_slot_map DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    slot_map_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // mostly short idles, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic in_word_t make_word(logic [2:0] op, logic [SLOT_W-1:0] h,
                                           logic [VALUE_WIDTH-1:0] v);
        in_word_t w;
        w.operation = op;
        w.handle = h;
        w.element_value = v;
        return w;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // handles mostly from a low window, where the live ones tend to sit
    function automatic in_word_t random_word(int ins_pct, int del_pct, int hwin);
        logic [2:0]        op;
        logic [SLOT_W-1:0] h;
        int                r;
        int                pick;
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            op = OP_INSERT;
        end else if (r < ins_pct + del_pct) begin
            op = OP_DELETE;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
            else if (pick < 7)
                op = OP_INCR;
            else if (pick < 14)
                op = OP_DECR;
            else
                op = OP_READ;
        end
        if ($urandom_range(0, 9) == 0)
            h = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
        else
            h = SLOT_W'($urandom_range(0, hwin));
        return make_word(op, h, pick_value());
    endfunction

    // present one word, holding it until the block takes it
    task automatic send_word(in_word_t w);
        int gap;
        gap = 0;
        if (!at_speed) begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) < 3)
                calm_left = $urandom_range(30, 80);
            else
                gap = idle_length();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off until every result is back, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_phase(int count, int ins_pct, int del_pct, int hwin);
        for (int i = 0; i < count; i++) begin
            send_word(random_word(ins_pct, del_pct, hwin));
            if ($urandom_range(0, 199) == 0)
                settle();
        end
    endtask

    // result channel back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (at_speed) begin
                m_ready <= 1'b1;
            end else if (ready_left > 0) begin
                ready_left--;
            end else if ($urandom_range(0, 99) < 55) begin
                m_ready <= 1'b1;
                ready_left = $urandom_range(0, 30);
            end else begin
                m_ready <= 1'b0;
                ready_left = idle_length();
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fresh handles, relocation, reuse, bad handles, count limits
        send_word(make_word(OP_READ, 8'd0, '0));
        send_word(make_word(OP_INSERT, 8'd0, '0));
        send_word(make_word(OP_INSERT, 8'd255, '1));
        send_word(make_word(OP_INSERT, 8'd7, 32'hA5A5_5A5A));
        send_word(make_word(OP_READ, 8'd1, '1));
        send_word(make_word(OP_DECR, 8'd0, '0));
        send_word(make_word(OP_INCR, 8'd0, '0));
        send_word(make_word(OP_DELETE, 8'd0, '0));
        send_word(make_word(OP_DECR, 8'd0, '0));
        send_word(make_word(OP_READ, 8'd2, '0));
        send_word(make_word(OP_DELETE, 8'd0, '0));
        send_word(make_word(OP_INCR, 8'd0, '0));
        send_word(make_word(OP_DECR, 8'd0, '0));
        send_word(make_word(OP_DELETE, 8'd1, '0));
        send_word(make_word(OP_INSERT, 8'd0, 32'h1234_5678));
        send_word(make_word(OP_READ, 8'd1, '0));
        send_word(make_word(OP_READ, 8'd255, '1));
        send_word(make_word(OP_DELETE, 8'd128, '0));
        send_word(make_word(OP_SPARE_A, 8'd255, '1));
        send_word(make_word(OP_SPARE_B, 8'd85, $urandom));
        send_word(make_word(OP_SPARE_C, 8'd170, $urandom));
        send_word(make_word(OP_INSERT, 8'd3, 32'h8000_0001));
        settle();

        // run one handle's count up and part of the way back down at full speed
        at_speed <= 1'b1;
        for (int i = 0; i < 24; i++)
            send_word(make_word(OP_INCR, 8'd2, pick_value()));
        send_word(make_word(OP_READ, 8'd2, '0));
        for (int i = 0; i < 3; i++)
            send_word(make_word(OP_DECR, 8'd2, '0));
        settle();
        at_speed <= 1'b0;

        // small table churn
        random_phase(700, 30, 12, 15);
        settle();

        // fill to the top, with inserts beyond capacity
        for (int i = 0; i < 270; i++)
            send_word(make_word(OP_INSERT, SLOT_W'($urandom), pick_value()));
        random_phase(400, 10, 15, MAX_SLOTS - 1);
        settle();

        // empty it again, then churn once more
        random_phase(300, 5, 45, MAX_SLOTS - 1);
        random_phase(280, 30, 12, 31);
        settle();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== refcounted_slot_map.f =====
rtl/core/rsm_pkg.sv
rtl/core/rsm_ram.sv
rtl/core/refcounted_slot_map.sv
sim/slot_map_checker.sv
sim/tb.sv
